[rtl/core/dwsc_pkg.sv]
package dwsc_pkg;

  localparam int CntW  = 16;
  localparam int FreqW = 20;
  localparam int AccW  = 16;
  localparam int OdoW  = 32;
  localparam logic [FreqW-1:0] FreqScale = 20'd1000000;
  localparam logic [4:0] StallMax = 5'd31;

  typedef enum logic [1:0] {
    OP_CAP_ONE = 2'd0,
    OP_CAP_TWO = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_SPEED_GAIN   = 2'd0,
    CFG_TURN_GAIN    = 2'd1,
    CFG_DRIVE_OFFSET = 2'd2,
    CFG_STALL_LIMIT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TICK_A,
    ST_TICK_B,
    ST_TICK_C,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch the input beat
    logic capture;   // apply capture update, start divide if pair completes
    logic div_step;  // one divider iteration
    logic div_done;  // write the quotient
    logic tick_a;    // stall handling
    logic tick_b;    // error products
    logic tick_c;    // accumulator update
    logic emit;      // load output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_cap;
    logic is_tick;
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

[rtl/core/dual_wheel_speed_capture_and_control.sv]
// Each beat runs from the accepting cycle in ST_IDLE through ST_TICK_A to
// the cycle in ST_OUT that loads the output register. A capture completing
// a pair also passes the bit-serial frequency divider (ST_DIV) and ST_TICK_C;
// a tick also passes ST_TICK_B and ST_TICK_C. Throughput: one beat at a
// time; the next beat is taken once the result has moved into the output
// register, so the divider sets the worst case. Reset (rst_n low, synchronous)
// restores register defaults, clears the wheel state except first_r and drops out_valid.
module dual_wheel_speed_capture_and_control (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [15:0]        in_capture_value,
  input  logic signed [16:0] in_target_speed,
  input  logic signed [15:0] in_target_turn,
  input  logic signed [23:0] in_yaw_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_report_valid,
  output logic signed [20:0] out_speed_report,
  output logic signed [31:0] out_odometer,
  output logic [15:0]        out_compare_one,
  output logic [15:0]        out_compare_two
);
  import dwsc_pkg::*;

  // The controller sequences each beat; the datapath holds the register and wheel state.
  cmd_t cmd;
  sts_t sts;

  dwsc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd
  );

  dwsc_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .in_opcode, .in_capture_value, .in_target_speed, .in_target_turn,
    .in_yaw_rate, .out_report_valid, .out_speed_report, .out_odometer,
    .out_compare_one, .out_compare_two
  );

endmodule

[rtl/core/dwsc_ctrl.sv]
module dwsc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  dwsc_pkg::sts_t sts,
  output dwsc_pkg::cmd_t cmd
);
  import dwsc_pkg::*;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TICK_A;
        end
      end
      ST_TICK_A: begin
        if (sts.is_cap) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.need_div ? ST_DIV : ST_OUT;
        end else if (sts.is_tick) begin
          cmd.tick_a = 1'b1;
          state_nxt  = ST_TICK_B;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_TICK_C;
        end
      end
      ST_TICK_B: begin
        cmd.tick_b = 1'b1;
        state_nxt  = ST_TICK_C;
      end
      ST_TICK_C: begin
        if (sts.is_tick) begin
          cmd.tick_c = 1'b1;
        end else begin
          cmd.div_done = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r) else $error("emit lost");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready)) else $error("overwrite of held result");
`endif
endmodule

[rtl/core/dwsc_dp.sv]
module dwsc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dwsc_pkg::cmd_t                 cmd,
  output dwsc_pkg::sts_t                 sts,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic [1:0]                     in_opcode,
  input  logic [15:0]                    in_capture_value,
  input  logic signed [16:0]             in_target_speed,
  input  logic signed [15:0]             in_target_turn,
  input  logic signed [23:0]             in_yaw_rate,
  output logic                           out_report_valid,
  output logic signed [20:0]             out_speed_report,
  output logic signed [31:0]             out_odometer,
  output logic [15:0]                    out_compare_one,
  output logic [15:0]                    out_compare_two
);
  import dwsc_pkg::*;

  logic [15:0] speed_gain_r, turn_gain_r, drive_offset_r;
  logic [3:0]  stall_limit_r;

  logic [1:0]              op_r;
  logic [CntW-1:0]         cap_r;
  logic signed [16:0]      tspeed_r;
  logic signed [15:0]      tturn_r;
  logic signed [23:0]      yaw_r;

  logic              phase_r   [2];
  logic [CntW-1:0]   first_r   [2];
  logic [FreqW-1:0]  freq_r    [2];
  logic [FreqW-1:0]  prev_r    [2];
  logic [4:0]        stall_r   [2];
  logic [OdoW-1:0]   odo_r     [2];
  logic [AccW-1:0]   acc_r     [2];

  // Restoring divider: 1000000 / period, one quotient bit per cycle.
  logic [FreqW-1:0]  quo_r;
  logic [CntW:0]     rem_r;
  logic [4:0]        cnt_r;
  logic [CntW-1:0]   dvs_r;
  logic              zero_div_r;
  logic [CntW:0]     rem_sh;
  logic [CntW:0]     rem_sub;

  logic signed [45:0] sterm_r;
  logic signed [42:0] tterm_r;

  logic              w;
  logic [CntW-1:0]   diff;
  logic [FreqW-1:0]  quo_final;
  logic [16:0]       spd_abs;
  logic signed [21:0] es2;
  logic signed [24:0] et;
  logic signed [38:0] sprod;
  logic signed [41:0] tprod;
  logic signed [46:0] n_one, n_two;
  logic [AccW-1:0]   acc_one_nxt, acc_two_nxt;
  logic [16:0]       sum_one, sum_two;

  assign w    = op_r[0];
  assign diff = cap_r - first_r[w];

  assign sts.is_cap   = (op_r == OP_CAP_ONE) || (op_r == OP_CAP_TWO);
  assign sts.is_tick  = (op_r == OP_TICK);
  assign sts.need_div = phase_r[w];
  assign sts.div_last = (cnt_r == 5'd0);

  assign rem_sh    = {rem_r[CntW-1:0], FreqScale[cnt_r]};
  assign rem_sub   = rem_sh - {1'b0, dvs_r};
  assign quo_final = zero_div_r ? FreqScale : quo_r;

  assign spd_abs = tspeed_r[16] ? 17'(-tspeed_r) : 17'(tspeed_r);
  assign es2 = $signed({4'd0, spd_abs, 1'b0}) - $signed({2'd0, freq_r[0]})
             - $signed({2'd0, freq_r[1]});
  assign et  = 25'(tturn_r) * 25'sd256 - 25'(yaw_r);

  assign sprod = $signed({1'b0, speed_gain_r}) * 39'(es2);
  assign tprod = $signed({1'b0, turn_gain_r}) * 42'(et);

  function automatic logic [AccW-1:0] clamp_q(input logic signed [46:0] n);
    logic signed [46:0] q;
    q = n / 47'sd65536;
    if (q < 0) return '0;
    if (q > 47'sd65535) return 16'hFFFF;
    return q[AccW-1:0];
  endfunction

  assign n_one = $signed({15'd0, acc_r[0], 16'd0}) + 47'(sterm_r)
               + (tspeed_r[16] ? 47'(tterm_r) : -47'(tterm_r));
  assign n_two = $signed({15'd0, acc_r[1], 16'd0}) + 47'(sterm_r)
               + (tspeed_r[16] ? -47'(tterm_r) : 47'(tterm_r));
  assign acc_one_nxt = clamp_q(n_one);
  assign acc_two_nxt = clamp_q(n_two);

  assign sum_one = {1'b0, drive_offset_r} + {1'b0, acc_r[0]};
  assign sum_two = {1'b0, drive_offset_r} + {1'b0, acc_r[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_gain_r   <= 16'd256;
      turn_gain_r    <= 16'd256;
      drive_offset_r <= 16'd900;
      stall_limit_r  <= 4'd8;
      for (int i = 0; i < 2; i++) begin
        phase_r[i] <= 1'b0;
        freq_r[i]  <= '0;
        prev_r[i]  <= '0;
        stall_r[i] <= '0;
        odo_r[i]   <= '0;
        acc_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SPEED_GAIN:   speed_gain_r   <= cfg_data;
          CFG_TURN_GAIN:    turn_gain_r    <= cfg_data;
          CFG_DRIVE_OFFSET: drive_offset_r <= cfg_data;
          CFG_STALL_LIMIT:  stall_limit_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        odo_r[w]   <= tspeed_r[16] ? odo_r[w] - 32'd1 : odo_r[w] + 32'd1;
        phase_r[w] <= !phase_r[w];
        if (!phase_r[w]) first_r[w] <= cap_r;
      end
      if (cmd.div_done) freq_r[w] <= quo_final;
      if (cmd.tick_a) begin
        for (int i = 0; i < 2; i++) begin
          logic [4:0] sc;
          sc = (freq_r[i] == prev_r[i]) ? ((stall_r[i] < StallMax) ? stall_r[i] + 5'd1
                                                                   : stall_r[i]) : 5'd0;
          stall_r[i] <= sc;
          if (sc > {1'b0, stall_limit_r}) begin
            freq_r[i] <= '0;
            prev_r[i] <= '0;
          end else begin
            prev_r[i] <= freq_r[i];
          end
        end
      end
      if (cmd.tick_c) begin
        acc_r[0] <= acc_one_nxt;
        acc_r[1] <= acc_two_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      cap_r    <= in_capture_value[CntW-1:0];
      tspeed_r <= in_target_speed;
      tturn_r  <= in_target_turn;
      yaw_r    <= in_yaw_rate;
    end
    if (cmd.capture) begin
      quo_r      <= '0;
      rem_r      <= '0;
      cnt_r      <= 5'(FreqW - 1);
      dvs_r      <= diff;
      zero_div_r <= (diff == '0);
    end
    if (cmd.div_step) begin
      if (!rem_sub[CntW]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[FreqW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[FreqW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 5'd1;
    end
    if (cmd.tick_b) begin
      sterm_r <= {sprod, 7'd0};
      tterm_r <= 43'(tprod);
    end
    if (cmd.emit) begin
      out_report_valid <= sts.is_cap && !phase_r[w] && cmd.emit;
      out_speed_report <= (sts.is_cap && !phase_r[w])
                        ? (tspeed_r[16] ? -$signed({1'b0, freq_r[w]})
                                        : $signed({1'b0, freq_r[w]})) : '0;
      out_odometer     <= sts.is_cap ? odo_r[w] : '0;
      out_compare_one  <= sum_one[16] ? 16'hFFFF : sum_one[15:0];
      out_compare_two  <= sum_two[16] ? 16'hFFFF : sum_two[15:0];
    end
  end

`ifndef SYNTH
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_done |-> !sts.is_tick) else $error("divide on tick");
  a_acc_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_c |-> sts.is_tick) else $error("accumulator update off tick");
  a_cap_op: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> sts.is_cap) else $error("capture on wrong opcode");
`endif
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

// Scoreboard: holds the wheel and drive state and predicts each result beat.
class wheel_drive_scoreboard;
  typedef struct packed {
    logic        rvalid;
    logic [20:0] report;
    logic [31:0] odo;
    logic [15:0] cmp1;
    logic [15:0] cmp2;
  } result_t;

  logic [15:0] speed_gain, turn_gain, drive_offset;
  logic [3:0]  stall_limit;
  logic        phase [2];
  logic [15:0] first_time [2];
  logic [19:0] freq [2];
  logic [19:0] prev_freq [2];
  logic [4:0]  stall_cnt [2];
  logic [31:0] odo [2];
  longint      acc [2];
  result_t     pending [$];
  int          mismatches;

  function void reset_state();
    speed_gain = 256;
    turn_gain = 256;
    drive_offset = 900;
    stall_limit = 8;
    for (int w = 0; w < 2; w++) begin
      phase[w] = 0;
      first_time[w] = 0;
      freq[w] = 0;
      prev_freq[w] = 0;
      stall_cnt[w] = 0;
      odo[w] = 0;
      acc[w] = 0;
    end
  endfunction

  function void write_reg(dwsc_pkg::cfg_idx_t idx, logic [15:0] val);
    case (idx)
      dwsc_pkg::CFG_SPEED_GAIN:   speed_gain = val;
      dwsc_pkg::CFG_TURN_GAIN:    turn_gain = val;
      dwsc_pkg::CFG_DRIVE_OFFSET: drive_offset = val;
      default:                    stall_limit = val[3:0];
    endcase
  endfunction

  function logic [15:0] compare_of(int w);
    longint c;
    c = longint'(drive_offset) + acc[w];
    return (c > 65535) ? 16'hFFFF : c[15:0];
  endfunction

  // Truncate toward zero, then clamp to the accumulator range.
  function longint clamp_acc(longint n);
    longint q;
    q = n / 65536;
    if (q < 0) return 0;
    if (q > 65535) return 65535;
    return q;
  endfunction

  function void note_input(logic [1:0] op, logic [15:0] cap, logic signed [16:0] ts,
                           logic signed [15:0] tt, logic signed [23:0] yaw);
    result_t r;
    logic [15:0] diff;
    logic [19:0] f;
    longint s, es2, et, sterm, tterm;
    int w;
    r = '0;
    if (op == dwsc_pkg::OP_CAP_ONE || op == dwsc_pkg::OP_CAP_TWO) begin
      w = (op == dwsc_pkg::OP_CAP_ONE) ? 0 : 1;
      odo[w] = (ts < 0) ? odo[w] - 1 : odo[w] + 1;
      if (!phase[w]) begin
        first_time[w] = cap;
        phase[w] = 1;
      end else begin
        diff = cap - first_time[w];
        f = (diff == 0) ? 20'd1000000 : 20'(1000000 / diff);
        freq[w] = f;
        phase[w] = 0;
        r.rvalid = 1;
        r.report = (ts < 0) ? 21'(-int'(f)) : 21'(f);
      end
      r.odo = odo[w];
    end else if (op == dwsc_pkg::OP_TICK) begin
      for (int k = 0; k < 2; k++) begin
        if (freq[k] == prev_freq[k]) begin
          if (stall_cnt[k] < 31) stall_cnt[k]++;
        end else begin
          stall_cnt[k] = 0;
        end
        if (stall_cnt[k] > stall_limit) freq[k] = 0;
        prev_freq[k] = freq[k];
      end
      s = (ts < 0) ? -longint'(ts) : longint'(ts);
      es2 = 2 * s - longint'(freq[0]) - longint'(freq[1]);
      et = longint'(tt) * 256 - longint'(yaw);
      sterm = longint'(speed_gain) * es2 * 128;
      tterm = longint'(turn_gain) * et;
      if (ts >= 0) begin
        acc[0] = clamp_acc(acc[0] * 65536 + sterm - tterm);
        acc[1] = clamp_acc(acc[1] * 65536 + sterm + tterm);
      end else begin
        acc[0] = clamp_acc(acc[0] * 65536 + sterm + tterm);
        acc[1] = clamp_acc(acc[1] * 65536 + sterm - tterm);
      end
    end
    r.cmp1 = compare_of(0);
    r.cmp2 = compare_of(1);
    pending.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t exp_r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: exp v=%0d rep=%h odo=%h c1=%h c2=%h,",
                  " got v=%0d rep=%h odo=%h c1=%h c2=%h"},
                 exp_r.rvalid, exp_r.report, exp_r.odo, exp_r.cmp1, exp_r.cmp2,
                 got.rvalid, got.report, got.odo, got.cmp1, got.cmp2);
    end
  endfunction
endclass

module testbench;
  import dwsc_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [15:0]        in_capture_value;
  logic signed [16:0] in_target_speed;
  logic signed [15:0] in_target_turn;
  logic signed [23:0] in_yaw_rate;
  logic               out_valid;
  logic               out_ready;
  logic               out_report_valid;
  logic signed [20:0] out_speed_report;
  logic signed [31:0] out_odometer;
  logic [15:0]        out_compare_one;
  logic [15:0]        out_compare_two;

  wheel_drive_scoreboard wheels;

  // Receiver behavior: quiet_tail disables stalls, hold_off forces a long one.
  bit quiet_tail;
  bit hold_off;
  int beats_sent;

  dual_wheel_speed_capture_and_control u_top (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

  // Send one beat; valid stays high until the handshake is seen at a rising edge.
  // Valid is left high afterwards; the next beat or an idle stretch takes it over.
  task automatic send_beat(logic [1:0] op, logic [15:0] cap, logic signed [16:0] ts,
                           logic signed [15:0] tt, logic signed [23:0] yaw);
    in_valid <= 1;
    in_opcode <= op;
    in_capture_value <= cap;
    in_target_speed <= ts;
    in_target_turn <= tt;
    in_yaw_rate <= yaw;
    do @(posedge clk); while (!in_ready);
    wheels.note_input(op, cap, ts, tt, yaw);
    beats_sent++;
    @(negedge clk);
  endtask

  // Random sender gap between beats, none near the end.
  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Every beat is one result, so waiting on an empty queue means the block is idle.
  task automatic drain();
    in_valid <= 0;
    while (wheels.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Write enable stays high across back-to-back writes; the caller drops it.
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    wheels.write_reg(idx, val);
    @(negedge clk);
  endtask

  // One random beat: a capture on either wheel, a tick or the unused opcode; keeps the loop busy.
  task automatic random_item(logic signed [16:0] ts);
    int r;
    logic [1:0] op;
    logic [15:0] cap;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_CAP_ONE;
    else if (r < 80) op = OP_CAP_TWO;
    else if (r < 97) op = OP_TICK;
    else op = OP_NONE;
    cap = 16'($urandom);
    if ($urandom_range(0, 9) == 0) ts = 17'($urandom);
    send_beat(op, cap, ts, 16'($urandom),
              $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 2047)));
  endtask

  // Output side: random stall bursts, a forced long hold-off, checking at each accept.
  initial begin
    int burst;
    out_ready = 0;
    @(posedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
      end else if (!quiet_tail && burst == 0 && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
      end
      if (!hold_off) begin
        if (burst > 0) begin
          out_ready <= 0;
          burst--;
        end else begin
          out_ready <= 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      wheels.check_result({out_report_valid, out_speed_report, out_odometer,
                           out_compare_one, out_compare_two});
  end

  initial begin
    logic signed [16:0] ts;
    wheels = new();
    wheels.reset_state();
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_SPEED_GAIN;
    cfg_data = 0;
    in_valid = 0;
    in_opcode = OP_NONE;
    in_capture_value = 0;
    in_target_speed = 0;
    in_target_turn = 0;
    in_yaw_rate = 0;
    quiet_tail = 0;
    hold_off = 0;
    beats_sent = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: zero period, extreme periods, both signs, every opcode, unused opcode.
    send_beat(OP_CAP_ONE, 16'h0000, 17'sd100, 0, 0);
    send_beat(OP_CAP_ONE, 16'h0000, 17'sd100, 0, 0);
    send_beat(OP_CAP_TWO, 16'hFFFF, -17'sd65536, 0, 0);
    send_beat(OP_CAP_TWO, 16'hFFFE, -17'sd65536, 0, 0);
    send_beat(OP_CAP_ONE, 16'h0001, 17'sd65535, 0, 0);
    send_beat(OP_CAP_ONE, 16'h0000, 17'sd65535, 0, 0);
    send_beat(OP_TICK, 0, 17'sd65535, 16'sh7FFF, 24'sh800000);
    send_beat(OP_TICK, 0, -17'sd65536, -16'sh8000, 24'sh7FFFFF);
    send_beat(OP_NONE, 16'hFFFF, -17'sd1, -16'sd1, -24'sd1);
    send_beat(OP_TICK, 0, 0, 0, 0);
    // Unchanged frequencies: enough ticks to exceed the stall limit.
    repeat (12) send_beat(OP_TICK, 0, 17'sd500, 0, 0);
    drain();

    // Phases over register settings, extremes included.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_SPEED_GAIN, 16'h0000); write_reg(CFG_TURN_GAIN, 16'hFFFF);
          write_reg(CFG_DRIVE_OFFSET, 16'hFFFF); write_reg(CFG_STALL_LIMIT, 16'd0);
        end
        1: begin
          write_reg(CFG_SPEED_GAIN, 16'hFFFF); write_reg(CFG_TURN_GAIN, 16'h0000);
          write_reg(CFG_DRIVE_OFFSET, 16'h0000); write_reg(CFG_STALL_LIMIT, 16'd15);
        end
        default: begin
          write_reg(CFG_SPEED_GAIN, 16'($urandom_range(0, 1023)));
          write_reg(CFG_TURN_GAIN, 16'($urandom_range(0, 1023)));
          write_reg(CFG_DRIVE_OFFSET, 16'($urandom));
          write_reg(CFG_STALL_LIMIT, 16'($urandom_range(0, 15)));
        end
      endcase
      cfg_we <= 0;
      ts = $urandom_range(0, 1) ? 17'($urandom_range(0, 3000)) : 17'(-$urandom_range(0, 3000));
      if (p == 2) begin
        // Long receiver hold-off while the sender keeps going: the block must backpressure.
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk);
            hold_off = 0;
          end
          repeat (20) random_item(ts);
        join
      end
      if (p == 5) quiet_tail = 1;
      repeat (170) begin
        random_item(ts);
        sender_gap();
      end
      drain();
    end

    if (wheels.mismatches == 0 && wheels.pending.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule
